### hw/rtl/swlcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlcw_pkg
// Shared types and constants for the single-wire LED chain writer.
// ----------------------------------------------------------------------------
package swlcw_pkg;

    localparam int LEVEL_W   = 8;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_GAP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_GAP    = 2'd2;

    localparam logic [7:0] CHAIN_LENGTH_RST = 8'd26;
    localparam logic [7:0] END_GAP_RST      = 8'd24;
    localparam logic [7:0] LATCH_GAP_RST    = 8'd60;

    // item kinds
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    localparam logic [7:0] SYMBOL_UNITS    = 8'd6;
    localparam logic [4:0] FRAME_SYMBOLS   = 5'd2;
    localparam logic [4:0] CMD_SYMBOLS     = 5'd6;
    localparam logic [4:0] PAYLOAD_SYMBOLS = 5'd30;
    localparam logic [5:0] CMD_PATTERN     = 6'b111010;

    typedef struct packed {
        logic [7:0] chain_length;
        logic [7:0] end_gap_units;
        logic [7:0] latch_gap_units;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         device_index;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } item_t;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic accepted;
        logic done_res;
    } result_t;

endpackage

### hw/rtl/swlcw_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlcw_cfg
// Configuration registers: chain length and the two gap lengths.
// ----------------------------------------------------------------------------
module swlcw_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [swlcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_wdata,
    output swlcw_pkg::cfg_t                cfg
);

    swlcw_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chain_length    <= swlcw_pkg::CHAIN_LENGTH_RST;
            cfg_reg.end_gap_units   <= swlcw_pkg::END_GAP_RST;
            cfg_reg.latch_gap_units <= swlcw_pkg::LATCH_GAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                swlcw_pkg::CFG_CHAIN_LENGTH: cfg_reg.chain_length    <= cfg_wdata;
                swlcw_pkg::CFG_END_GAP:      cfg_reg.end_gap_units   <= cfg_wdata;
                swlcw_pkg::CFG_LATCH_GAP:    cfg_reg.latch_gap_units <= cfg_wdata;
                default:                     cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/swlcw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlcw_core
// Waveform sequencer: advances the chain state by one item per step and
// registers the result.
// ----------------------------------------------------------------------------
module swlcw_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  swlcw_pkg::item_t   item,
    input  swlcw_pkg::cfg_t    cfg,
    output swlcw_pkg::result_t result
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_FRAME   = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_EOS     = 3'd3,
        PH_LATCH   = 3'd4
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         chip_counter_reg, chip_counter_next;
    logic [4:0]         symbol_counter_reg, symbol_counter_next;
    logic [7:0]         unit_counter_reg, unit_counter_next;
    logic [23:0]        color_shift_reg, color_shift_next;
    logic [7:0]         target_chip_reg, target_chip_next;
    logic               line_level_reg, line_level_next;
    swlcw_pkg::result_t result_reg, result_next;

    logic [7:0] unit_inc;
    logic [4:0] sym_inc;
    logic [7:0] chip_inc;
    logic       sym_done;
    logic       data_bit;
    logic [2:0] cmd_pos;

    function automatic logic symbol_level(input logic bit_val, input logic [7:0] unit);
        symbol_level = (unit == 8'd0) || ((unit == 8'd2) && bit_val);
    endfunction

    function automatic logic [7:0] gap_len(input logic [7:0] gap);
        gap_len = (gap == 8'd0) ? 8'd1 : gap;
    endfunction

    assign unit_inc = unit_counter_reg + 8'd1;
    assign sym_inc  = symbol_counter_reg + 5'd1;
    assign chip_inc = chip_counter_reg + 8'd1;
    assign sym_done = unit_inc >= swlcw_pkg::SYMBOL_UNITS;
    // command bits go out msb first
    assign cmd_pos  = 3'd5 - symbol_counter_reg[2:0];
    assign data_bit = (symbol_counter_reg < swlcw_pkg::CMD_SYMBOLS)
                      ? swlcw_pkg::CMD_PATTERN[cmd_pos] : color_shift_reg[23];

    always_comb
    begin
        phase_next          = phase_reg;
        chip_counter_next   = chip_counter_reg;
        symbol_counter_next = symbol_counter_reg;
        unit_counter_next   = unit_counter_reg;
        color_shift_next    = color_shift_reg;
        target_chip_next    = target_chip_reg;
        line_level_next     = line_level_reg;
        result_next.pin_level = line_level_reg;
        result_next.accepted  = 1'b0;
        result_next.done_res  = 1'b0;

        if (item.kind == swlcw_pkg::KIND_REQUEST)
        begin
            // requests take no time on the line
            if (phase_reg == PH_IDLE)
            begin
                target_chip_next    = item.device_index;
                color_shift_next    = {item.blue_level, item.green_level, item.red_level};
                chip_counter_next   = 8'd0;
                symbol_counter_next = 5'd0;
                unit_counter_next   = 8'd0;
                phase_next          = (cfg.chain_length == 8'd0) ? PH_LATCH : PH_FRAME;
                result_next.accepted = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_FRAME:
                begin
                    result_next.pin_level = symbol_level(1'b0, unit_counter_reg);
                    unit_counter_next = unit_inc;
                    if (sym_done)
                    begin
                        unit_counter_next   = 8'd0;
                        symbol_counter_next = sym_inc;
                        if (sym_inc >= swlcw_pkg::FRAME_SYMBOLS)
                        begin
                            symbol_counter_next = 5'd0;
                            phase_next = (chip_counter_reg == target_chip_reg)
                                         ? PH_PAYLOAD : PH_EOS;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    result_next.pin_level = symbol_level(data_bit, unit_counter_reg);
                    unit_counter_next = unit_inc;
                    if (sym_done)
                    begin
                        unit_counter_next = 8'd0;
                        if (symbol_counter_reg >= swlcw_pkg::CMD_SYMBOLS)
                            color_shift_next = {color_shift_reg[22:0], 1'b0};
                        symbol_counter_next = sym_inc;
                        if (sym_inc >= swlcw_pkg::PAYLOAD_SYMBOLS)
                        begin
                            symbol_counter_next = 5'd0;
                            phase_next = PH_EOS;
                        end
                    end
                end
                PH_EOS:
                begin
                    result_next.pin_level = 1'b0;
                    unit_counter_next = unit_inc;
                    if (unit_inc >= gap_len(cfg.end_gap_units))
                    begin
                        unit_counter_next = 8'd0;
                        chip_counter_next = chip_inc;
                        phase_next = (chip_inc >= cfg.chain_length) ? PH_LATCH : PH_FRAME;
                    end
                end
                PH_LATCH:
                begin
                    result_next.pin_level = 1'b0;
                    unit_counter_next = unit_inc;
                    if (unit_inc >= gap_len(cfg.latch_gap_units))
                    begin
                        unit_counter_next    = 8'd0;
                        phase_next           = PH_IDLE;
                        result_next.done_res = 1'b1;
                    end
                end
                default:
                begin
                    phase_next            = PH_IDLE;
                    result_next.pin_level = 1'b0;
                end
            endcase
            line_level_next = result_next.pin_level;
        end

        result_next.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            chip_counter_reg   <= 8'd0;
            symbol_counter_reg <= 5'd0;
            unit_counter_reg   <= 8'd0;
            color_shift_reg    <= 24'd0;
            target_chip_reg    <= 8'd0;
            line_level_reg     <= 1'b0;
            result_reg         <= '0;
        end
        else if (step_en)
        begin
            phase_reg          <= phase_next;
            chip_counter_reg   <= chip_counter_next;
            symbol_counter_reg <= symbol_counter_next;
            unit_counter_reg   <= unit_counter_next;
            color_shift_reg    <= color_shift_next;
            target_chip_reg    <= target_chip_next;
            line_level_reg     <= line_level_next;
            result_reg         <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### hw/rtl/single_wire_led_chain_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_led_chain_writer_unit
// Single-wire waveform writer for a daisy chain of RGB LED driver chips.
// ----------------------------------------------------------------------------
// Every item (a tick or a write request) gives exactly one result item. The
// block takes one item per clock cycle, sustained, as long as results are
// taken; an item goes through an input register and the sequencer's result
// register, and its result is offered from the result register. While a
// result waits, one more item can still be taken into the input register;
// after that the input stalls until the result is taken. Each tick item
// is one time unit of the line; requests take no time and are dropped
// (accepted = 0) while a chain write is in progress.
module single_wire_led_chain_writer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            kind,
    input  logic [7:0]                      device_index,
    input  logic [swlcw_pkg::LEVEL_W-1:0]   red_level,
    input  logic [swlcw_pkg::LEVEL_W-1:0]   green_level,
    input  logic [swlcw_pkg::LEVEL_W-1:0]   blue_level,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            pin_level,
    output logic                            busy_res,
    output logic                            accepted,
    output logic                            done_res,
    input  logic                            cfg_we,
    input  logic [swlcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_wdata
);

    swlcw_pkg::cfg_t    cfg;
    swlcw_pkg::item_t   item_reg;
    swlcw_pkg::result_t result;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               step_en;

    // the result register moves when empty or being drained
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign step_en  = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.kind         <= kind;
            item_reg.device_index <= device_index;
            item_reg.red_level    <= red_level;
            item_reg.green_level  <= green_level;
            item_reg.blue_level   <= blue_level;
        end
    end

    swlcw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    swlcw_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign out_valid = out_valid_reg;
    assign pin_level = result.pin_level;
    assign busy_res  = result.busy_res;
    assign accepted  = result.accepted;
    assign done_res  = result.done_res;

    // the transfer is over on the done item
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(done_res && busy_res))
        else $error("done and busy reported together");

    // a taken request always starts a transfer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> busy_res)
        else $error("request taken but block not busy");

    // the line rests low whenever no transfer is running
    a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pin_level) |-> busy_res)
        else $error("line high while idle");

    // a step always leaves a result in the result register
    a_step_src: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid_reg)
        else $error("result register not loaded after a step");

endmodule

### bench/swlcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swlcw_checker
// Watches both channels and the register port of the LED chain writer, runs
// its own model of the line sequencer on every accepted item and compares
// each result item, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module swlcw_checker
    import swlcw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 kind,
    input  logic [7:0]           device_index,
    input  logic [LEVEL_W-1:0]   red_level,
    input  logic [LEVEL_W-1:0]   green_level,
    input  logic [LEVEL_W-1:0]   blue_level,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 pin_level,
    input  logic                 busy_res,
    input  logic                 accepted,
    input  logic                 done_res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,
    output int                   mismatch_count,
    output int                   pending_results,
    output int                   results_seen,
    output int                   transfers_done,
    output int                   requests_taken,
    output logic                 chain_busy
);

    localparam int MAX_PRINT = 40;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_FRAME,
        SEQ_PAYLOAD,
        SEQ_END_GAP,
        SEQ_LATCH
    } seq_phase_e;

    // model copy of the registers and the sequencer
    logic [7:0]  chain_len_q;
    logic [7:0]  end_gap_q;
    logic [7:0]  latch_gap_q;
    seq_phase_e  phase_q;
    logic [7:0]  chip_cnt;
    logic [4:0]  sym_cnt;
    logic [7:0]  unit_cnt;
    logic [23:0] color_sr;
    logic [7:0]  target_chip;
    logic        line_q;

    result_t expected_line[$];

    // a zero gap register still gives one unit
    function automatic logic [7:0] gap_units(input logic [7:0] reg_val);
        return (reg_val == 8'd0) ? 8'd1 : reg_val;
    endfunction

    function automatic logic unit_level(input logic sym_bit, input logic [7:0] unit);
        return (unit == 8'd0) || ((unit == 8'd2) && sym_bit);
    endfunction

    // steps one unit inside a symbol, true when the symbol is over
    function automatic logic advance_unit();
        unit_cnt = unit_cnt + 8'd1;
        if (unit_cnt >= SYMBOL_UNITS)
        begin
            unit_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t line_step(input item_t it);
        result_t res;
        logic    sym_bit;
        res = '0;
        res.pin_level = line_q;
        if (it.kind == KIND_REQUEST)
        begin
            if (phase_q == SEQ_IDLE)
            begin
                target_chip = it.device_index;
                color_sr    = {it.blue_level, it.green_level, it.red_level};
                chip_cnt    = '0;
                sym_cnt     = '0;
                unit_cnt    = '0;
                phase_q     = (chain_len_q == 8'd0) ? SEQ_LATCH : SEQ_FRAME;
                res.accepted = 1'b1;
            end
        end
        else
        begin
            case (phase_q)
                SEQ_FRAME:
                begin
                    res.pin_level = unit_level(1'b0, unit_cnt);
                    if (advance_unit())
                    begin
                        sym_cnt = sym_cnt + 5'd1;
                        if (sym_cnt >= FRAME_SYMBOLS)
                        begin
                            sym_cnt = '0;
                            phase_q = (chip_cnt == target_chip) ? SEQ_PAYLOAD : SEQ_END_GAP;
                        end
                    end
                end
                SEQ_PAYLOAD:
                begin
                    // command first, then blue, green, red msb first
                    if (sym_cnt < CMD_SYMBOLS)
                        sym_bit = CMD_PATTERN[CMD_SYMBOLS - 5'd1 - sym_cnt];
                    else
                        sym_bit = color_sr[23];
                    res.pin_level = unit_level(sym_bit, unit_cnt);
                    if (advance_unit())
                    begin
                        if (sym_cnt >= CMD_SYMBOLS)
                            color_sr = color_sr << 1;
                        sym_cnt = sym_cnt + 5'd1;
                        if (sym_cnt >= PAYLOAD_SYMBOLS)
                        begin
                            sym_cnt = '0;
                            phase_q = SEQ_END_GAP;
                        end
                    end
                end
                SEQ_END_GAP:
                begin
                    res.pin_level = 1'b0;
                    unit_cnt = unit_cnt + 8'd1;
                    if (unit_cnt >= gap_units(end_gap_q))
                    begin
                        unit_cnt = '0;
                        chip_cnt = chip_cnt + 8'd1;
                        phase_q  = (chip_cnt >= chain_len_q) ? SEQ_LATCH : SEQ_FRAME;
                    end
                end
                SEQ_LATCH:
                begin
                    res.pin_level = 1'b0;
                    unit_cnt = unit_cnt + 8'd1;
                    if (unit_cnt >= gap_units(latch_gap_q))
                    begin
                        unit_cnt     = '0;
                        phase_q      = SEQ_IDLE;
                        res.done_res = 1'b1;
                    end
                end
                default:
                begin
                    phase_q       = SEQ_IDLE;
                    res.pin_level = 1'b0;
                end
            endcase
            line_q = res.pin_level;
        end
        res.busy_res = (phase_q != SEQ_IDLE);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= MAX_PRINT)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        item_t   it;
        if (!rst_n)
        begin
            chain_len_q     = CHAIN_LENGTH_RST;
            end_gap_q       = END_GAP_RST;
            latch_gap_q     = LATCH_GAP_RST;
            phase_q         = SEQ_IDLE;
            chip_cnt        = '0;
            sym_cnt         = '0;
            unit_cnt        = '0;
            color_sr        = '0;
            target_chip     = '0;
            line_q          = 1'b0;
            expected_line.delete();
            mismatch_count  = 0;
            pending_results = 0;
            results_seen    = 0;
            transfers_done  = 0;
            requests_taken  = 0;
            chain_busy      = 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CHAIN_LENGTH: chain_len_q = cfg_wdata;
                    CFG_END_GAP:      end_gap_q   = cfg_wdata;
                    CFG_LATCH_GAP:    latch_gap_q = cfg_wdata;
                    default:          ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                results_seen = results_seen + 1;
                if (expected_line.size() == 0)
                    report_mismatch("result with nothing expected", 1, 0);
                else
                begin
                    want = expected_line.pop_front();
                    if (pin_level !== want.pin_level)
                        report_mismatch("pin_level", int'(pin_level),
                                        int'(want.pin_level));
                    if (busy_res !== want.busy_res)
                        report_mismatch("busy_res", int'(busy_res),
                                        int'(want.busy_res));
                    if (accepted !== want.accepted)
                        report_mismatch("accepted", int'(accepted),
                                        int'(want.accepted));
                    if (done_res !== want.done_res)
                        report_mismatch("done_res", int'(done_res),
                                        int'(want.done_res));
                    if (want.done_res)
                        transfers_done = transfers_done + 1;
                end
            end

            if (in_valid && in_ready)
            begin
                it.kind         = kind;
                it.device_index = device_index;
                it.red_level    = red_level;
                it.green_level  = green_level;
                it.blue_level   = blue_level;
                want = line_step(it);
                if (want.accepted)
                    requests_taken = requests_taken + 1;
                expected_line.push_back(want);
            end

            pending_results = expected_line.size();
            chain_busy      = (phase_q != SEQ_IDLE);
        end
    end

endmodule

### bench/tb_single_wire_led_chain_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_single_wire_led_chain_writer_unit
// Drives ticks and write requests into the LED chain writer with random gaps
// and result stalls across a series of register settings, and lets the
// checker beside the block compare every result item with its prediction.
// ----------------------------------------------------------------------------
module tb_single_wire_led_chain_writer_unit;

    import swlcw_pkg::*;

    localparam int NUM_PHASES     = 12;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic                 kind         = KIND_TICK;
    logic [7:0]           device_index = '0;
    logic [LEVEL_W-1:0]   red_level    = '0;
    logic [LEVEL_W-1:0]   green_level  = '0;
    logic [LEVEL_W-1:0]   blue_level   = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic                 pin_level;
    logic                 busy_res;
    logic                 accepted;
    logic                 done_res;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [7:0]           cfg_wdata    = '0;

    int   mismatch_count;
    int   pending_results;
    int   results_seen;
    int   transfers_done;
    int   requests_taken;
    logic chain_busy;

    logic [7:0] cur_len;
    logic [7:0] cur_end_gap;
    logic [7:0] cur_latch_gap;
    bit         tx_steady = 1'b0;
    bit         rx_steady = 1'b0;
    bit         hold_req  = 1'b0;
    int         hold_left = 0;
    int         stall_left = 0;
    int         quiet_cycles = 0;

    single_wire_led_chain_writer_unit u_dut (.*);

    swlcw_checker u_check (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] len, input logic [7:0] end_gap,
                              input logic [7:0] latch_gap);
        write_reg(CFG_CHAIN_LENGTH, len);
        write_reg(CFG_END_GAP, end_gap);
        write_reg(CFG_LATCH_GAP, latch_gap);
        @(negedge clk);
        cfg_we        = 1'b0;
        cur_len       = len;
        cur_end_gap   = end_gap;
        cur_latch_gap = latch_gap;
    endtask

    // called at a falling edge, returns at the edge that takes the item
    task automatic push_item(input logic k, input logic [7:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        kind         = k;
        device_index = idx;
        red_level    = r;
        green_level  = g;
        blue_level   = b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic push_tick();
        @(negedge clk);
        push_item(KIND_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic push_request(input logic [7:0] idx, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b);
        @(negedge clk);
        push_item(KIND_REQUEST, idx, r, g, b);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left = hold_left - 1;
            end
            else if (stall_left > 0)
            begin
                out_ready  = 1'b0;
                stall_left = stall_left - 1;
            end
            else if (!rx_steady && $urandom_range(0, 99) < 20)
            begin
                out_ready  = 1'b0;
                stall_left = pick_gap();
            end
            else
                out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_single_wire_led_chain_writer_unit NOT OK");
            $finish;
        end
    end

    initial
    begin
        int         phase_items;
        int         phase_count;
        logic [7:0] idx;
        bit         busy_now;
        bit         hold_used;
        bit         pause_used;

        hold_used  = 1'b0;
        pause_used = 1'b0;
        cur_len       = CHAIN_LENGTH_RST;
        cur_end_gap   = END_GAP_RST;
        cur_latch_gap = LATCH_GAP_RST;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // idle tick under the reset settings
        push_tick();
        wait_drained();

        // one chip, zero gaps, unused index written once
        write_reg(CFG_UNUSED, 8'hAA);
        set_config(8'd1, 8'd0, 8'd0);
        push_request(8'd255, 8'hFF, 8'hFF, 8'hFF);
        repeat (3) push_tick();
        // dropped while the chain write runs
        push_request(8'd0, 8'h00, 8'h00, 8'h00);
        repeat (11) push_tick();
        push_tick();
        wait_drained();

        // empty chain sends only the latch gap
        set_config(8'd0, 8'd0, 8'd0);
        push_request(8'd0, 8'h5A, 8'hA5, 8'hC3);
        push_tick();
        push_tick();
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // settings change while a long write may still run, which then goes on under them
            case (ph)
                0:       set_config(CHAIN_LENGTH_RST, END_GAP_RST, LATCH_GAP_RST);
                1:       set_config(8'd1, 8'd1, 8'd1);
                2:       set_config(8'd255, 8'd255, 8'd255);
                3:       set_config(8'd2, 8'd0, 8'd0);
                4:       set_config(8'd0, 8'd9, 8'd3);
                5:       set_config(8'd1, 8'd255, 8'd255);
                6:       set_config(8'd255, 8'd0, 8'd0);
                7:       set_config(8'd3, 8'd2, 8'd1);
                default: set_config(8'($urandom_range(1, 4)), 8'($urandom_range(0, 6)),
                                    8'($urandom_range(0, 10)));
            endcase
            tx_steady = (ph % 4 == 3) || (ph == 10);
            rx_steady = (ph % 4 == 3);
            phase_items = (cur_len > 8 || cur_end_gap > 40 || cur_latch_gap > 40) ? 80 : 160;
            phase_count = 0;
            while (phase_count < phase_items)
            begin
                @(negedge clk);
                busy_now = chain_busy;
                if (!busy_now && $urandom_range(0, 99) < 50)
                begin
                    if (cur_len != 0 && $urandom_range(0, 99) < 60)
                        idx = 8'($urandom_range(0, cur_len - 1));
                    else
                        idx = 8'($urandom_range(0, 255));
                    push_item(KIND_REQUEST, idx, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    phase_count++;
                end
                else if (busy_now && $urandom_range(0, 99) < 3)
                    push_item(KIND_REQUEST, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                else
                begin
                    push_item(KIND_TICK, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                    phase_count++;
                end
                if (ph == 1 && phase_count == 40 && !hold_used)
                begin
                    hold_req  = 1'b1;
                    hold_used = 1'b1;
                end
                if (ph == 8 && phase_count == 60 && !pause_used)
                begin
                    wait_drained();
                    pause_used = 1'b1;
                end
            end
            wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        @(negedge clk);
        $display("checked %0d result items, %0d requests taken, %0d chain writes finished",
                 results_seen, requests_taken, transfers_done);
        $display("settings swept: reset, empty and one-chip chains, zero and full-scale gaps");
        if (mismatch_count == 0 && pending_results == 0)
            $display("tb_single_wire_led_chain_writer_unit OK");
        else
            $display("tb_single_wire_led_chain_writer_unit NOT OK");
        $finish;
    end

endmodule
